[src/gca_pkg.sv]
package gca_pkg;

	localparam int NUM_DEPOTS  = 8;
	localparam int MAX_VENDORS = 1024;

	localparam int DEPOT_W   = 3;
	localparam int DIST_W    = 20;
	localparam int AMOUNT_W  = 24;
	localparam int COST_W    = 22;
	localparam int TOTAL_W   = 32;
	localparam int VIDX_W    = 10;
	localparam int VCOUNT_W  = $clog2(MAX_VENDORS);
	localparam int CAP_IDX_W = (NUM_DEPOTS > 1) ? $clog2(NUM_DEPOTS) : 1;

	localparam logic [COST_W-1:0]   PENALTY_FACTOR = COST_W'(3);
	localparam logic [VCOUNT_W-1:0] VCOUNT_LAST    = VCOUNT_W'(MAX_VENDORS - 1);

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_OFFER = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                command;
		logic [DEPOT_W-1:0]  depot;
		logic [DIST_W-1:0]   distance;
		logic [AMOUNT_W-1:0] amount;
		logic                last_depot;
		logic                last_vendor;
	} req_t;

	typedef struct packed {
		logic [VIDX_W-1:0]  vendor_index;
		logic [DEPOT_W-1:0] chosen_depot;
		logic               assigned;
		logic [COST_W-1:0]  cost_added;
		logic [TOTAL_W-1:0] total_cost;
		logic               run_done;
	} result_t;

	typedef struct packed {
		logic                 en;
		logic [CAP_IDX_W-1:0] addr;
		logic [AMOUNT_W-1:0]  data;
	} cap_wr_t;

	function automatic logic depot_in_range(logic [DEPOT_W-1:0] d);
		return int'(d) < NUM_DEPOTS;
	endfunction

endpackage

[src/gca_cap_store.sv]
module gca_cap_store import gca_pkg::*; (
	input  logic                 clk,
	input  cap_wr_t              wr,
	input  logic [CAP_IDX_W-1:0] rd_addr,
	output logic [AMOUNT_W-1:0]  rd_data
);

	logic [AMOUNT_W-1:0] cap_q [NUM_DEPOTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			cap_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = cap_q[rd_addr];

endmodule

[src/gca_vendor_track.sv]
module gca_vendor_track import gca_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  req_t                req,
	input  logic [AMOUNT_W-1:0] cap_rd,
	output cap_wr_t             cap_wr,
	output logic                has_result,
	output result_t             result
);

	logic [DIST_W-1:0]   best_dist_q;
	logic [DEPOT_W-1:0]  best_dep_q;
	logic                found_q;
	logic [AMOUNT_W-1:0] best_amt_q;
	logic [AMOUNT_W-1:0] best_cap_q;
	logic [DIST_W-1:0]   largest_q;
	logic [VCOUNT_W-1:0] vcount_q;
	logic [TOTAL_W-1:0]  total_q;

	logic                in_range;
	logic                is_offer;
	logic                fit;
	logic [DIST_W-1:0]   best_dist_n;
	logic [DEPOT_W-1:0]  best_dep_n;
	logic                found_n;
	logic [AMOUNT_W-1:0] best_amt_n;
	logic [AMOUNT_W-1:0] best_cap_n;
	logic [DIST_W-1:0]   largest_n;
	logic [COST_W-1:0]   cost;
	logic [TOTAL_W:0]    sum;
	logic [TOTAL_W-1:0]  total_n;
	logic [AMOUNT_W-1:0] cap_left;

	assign in_range   = depot_in_range(req.depot);
	assign is_offer   = (req.command == CMD_OFFER);
	assign has_result = is_offer && req.last_depot;

	// candidate compare, first depot wins a tie
	assign fit = is_offer && in_range && (cap_rd >= req.amount)
		&& (!found_q || (req.distance < best_dist_q));

	always_comb begin
		best_dist_n = best_dist_q;
		best_dep_n  = best_dep_q;
		found_n     = found_q;
		best_amt_n  = best_amt_q;
		best_cap_n  = best_cap_q;
		largest_n   = largest_q;
		if (is_offer && in_range && (req.distance > largest_q)) begin
			largest_n = req.distance;
		end
		if (fit) begin
			best_dist_n = req.distance;
			best_dep_n  = req.depot;
			found_n     = 1'b1;
			best_amt_n  = req.amount;
			best_cap_n  = cap_rd;
		end
	end

	always_comb begin
		cost     = found_n ? COST_W'(best_dist_n) : COST_W'(largest_n) * PENALTY_FACTOR;
		sum      = {1'b0, total_q} + (TOTAL_W + 1)'(cost);
		total_n  = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
		cap_left = (best_cap_n >= best_amt_n) ? best_cap_n - best_amt_n : '0;
	end

	always_comb begin
		cap_wr = '0;
		if (!is_offer) begin
			cap_wr.en   = fire && in_range;
			cap_wr.addr = CAP_IDX_W'(req.depot);
			cap_wr.data = req.amount;
		end else begin
			cap_wr.en   = fire && has_result && found_n && depot_in_range(best_dep_n);
			cap_wr.addr = CAP_IDX_W'(best_dep_n);
			cap_wr.data = cap_left;
		end
	end

	always_comb begin
		result.vendor_index = VIDX_W'(vcount_q);
		result.chosen_depot = found_n ? best_dep_n : '0;
		result.assigned     = found_n;
		result.cost_added   = cost;
		result.total_cost   = total_n;
		result.run_done     = req.last_vendor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dist_q <= '1;
			best_dep_q  <= '0;
			found_q     <= 1'b0;
			best_amt_q  <= '0;
			best_cap_q  <= '0;
			largest_q   <= '0;
			vcount_q    <= '0;
			total_q     <= '0;
		end else if (fire) begin
			if (!is_offer) begin
				// a load may change the capacity of the kept depot
				if (in_range && (req.depot == best_dep_q)) begin
					best_cap_q <= req.amount;
				end
			end else if (has_result) begin
				best_dist_q <= '1;
				best_dep_q  <= '0;
				found_q     <= 1'b0;
				best_amt_q  <= '0;
				best_cap_q  <= '0;
				largest_q   <= '0;
				if (req.last_vendor) begin
					vcount_q <= '0;
					total_q  <= '0;
				end else begin
					vcount_q <= (vcount_q == VCOUNT_LAST) ? '0 : vcount_q + 1'b1;
					total_q  <= total_n;
				end
			end else begin
				best_dist_q <= best_dist_n;
				best_dep_q  <= best_dep_n;
				found_q     <= found_n;
				best_amt_q  <= best_amt_n;
				best_cap_q  <= best_cap_n;
				largest_q   <= largest_n;
			end
		end
	end

endmodule

[src/greedy_capacitated_assign.sv]
// greedy capacitated assignment of vendors to depots
//
// input channel (in_valid / in_ready): one request per cycle while in_ready
// is high, either a depot capacity load (command = 0) or a candidate depot
// offer for the current vendor (command = 1). last_depot on an offer closes
// the vendor; last_vendor on that same request also closes the run.
// output channel (out_valid / out_ready): one result per closed vendor with
// the chosen depot or the penalty, the cost added and the running total.
//
// a request accepted into the input register is evaluated there against the
// vendor state and the 8-entry capacity register file; its result is then
// registered in the output register that drives out_valid, and throughput
// is one request per cycle while in_ready is high.
// if the receiver stalls with a result still held, the input register keeps
// the next request only if it would produce a result; loads and non-final
// offers keep flowing. in_ready then stays low until out_ready returns.
// reset clears the vendor state, vendor count and run total; capacities are
// not cleared and must be loaded before depots are offered.
module greedy_capacitated_assign import gca_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic [DEPOT_W-1:0]  depot,
	input  logic [DIST_W-1:0]   distance,
	input  logic [AMOUNT_W-1:0] amount,
	input  logic                last_depot,
	input  logic                last_vendor,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [VIDX_W-1:0]   vendor_index,
	output logic [DEPOT_W-1:0]  chosen_depot,
	output logic                assigned,
	output logic [COST_W-1:0]   cost_added,
	output logic [TOTAL_W-1:0]  total_cost,
	output logic                run_done
);

	logic                s1_valid_q;
	req_t                req_s1;
	logic                s1_adv;
	logic                s1_fire;
	logic                s1_has_result;
	result_t             result;
	cap_wr_t             cap_wr;
	logic [AMOUNT_W-1:0] cap_rd;
	logic                out_valid_q;
	result_t             out_q;

	assign s1_adv   = !s1_has_result || !out_valid_q || out_ready;
	assign s1_fire  = s1_valid_q && s1_adv;
	assign in_ready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1.command     <= cmd_t'(command);
			req_s1.depot       <= depot;
			req_s1.distance    <= distance;
			req_s1.amount      <= amount;
			req_s1.last_depot  <= last_depot;
			req_s1.last_vendor <= last_vendor;
		end
	end

	gca_cap_store u_cap_store (
		.clk     (clk),
		.wr      (cap_wr),
		.rd_addr (CAP_IDX_W'(req_s1.depot)),
		.rd_data (cap_rd)
	);

	gca_vendor_track u_vendor_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (s1_fire),
		.req        (req_s1),
		.cap_rd     (cap_rd),
		.cap_wr     (cap_wr),
		.has_result (s1_has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && s1_has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && s1_has_result) begin
			out_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign vendor_index = out_q.vendor_index;
	assign chosen_depot = out_q.chosen_depot;
	assign assigned     = out_q.assigned;
	assign cost_added   = out_q.cost_added;
	assign total_cost   = out_q.total_cost;
	assign run_done     = out_q.run_done;

	// a decided vendor waiting on a full output must hold the input side
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && s1_has_result && out_valid_q && !out_ready |-> !in_ready)
		else $error("decision would overwrite a pending result");

	// only a held decision can block the input
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> s1_valid_q && s1_has_result)
		else $error("input stalled without a pending decision");

	// a penalty result reports depot zero
	a_penalty_depot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.assigned |-> out_q.chosen_depot == '0)
		else $error("penalty result with nonzero depot");

	// a closed run clears the vendor count
	a_run_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && s1_has_result && req_s1.last_vendor
		|=> u_vendor_track.vcount_q == '0)
		else $error("vendor count not cleared at end of run");

endmodule

[test/tb_greedy_capacitated_assign.sv]
`timescale 1ns / 100ps

module tb_greedy_capacitated_assign;
	import gca_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;
	localparam int WRAP_VENDORS = 1030;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	req_t drv = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [VIDX_W-1:0] vendor_index;
	logic [DEPOT_W-1:0] chosen_depot;
	logic assigned;
	logic [COST_W-1:0] cost_added;
	logic [TOTAL_W-1:0] total_cost;
	logic run_done;

	// requests waiting to be offered and decisions waiting to come out
	req_t pend_reqs[$];
	result_t due_decisions[$];

	int send_idle = 25;
	int recv_idle = 71;
	int errors = 0;
	int cycles = 0;
	logic hold_start = 1'b0;
	int hold_left = 0;

	// predicted block state
	logic [AMOUNT_W-1:0] cap_left [NUM_DEPOTS];
	logic [DIST_W-1:0] near_dist = '1;
	logic [DEPOT_W-1:0] near_depot = '0;
	logic have_fit = 1'b0;
	logic [AMOUNT_W-1:0] near_amt = '0;
	logic [DIST_W-1:0] far_dist = '0;
	logic [VCOUNT_W-1:0] vend_cnt = '0;
	logic [TOTAL_W-1:0] run_sum = '0;

	greedy_capacitated_assign i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(drv.command),
		.depot(drv.depot),
		.distance(drv.distance),
		.amount(drv.amount),
		.last_depot(drv.last_depot),
		.last_vendor(drv.last_vendor),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.vendor_index(vendor_index),
		.chosen_depot(chosen_depot),
		.assigned(assigned),
		.cost_added(cost_added),
		.total_cost(total_cost),
		.run_done(run_done)
	);

	always #2 clk = ~clk;

	function automatic void queue_req(req_t r);
		pend_reqs.insert(pend_reqs.size(), r);
	endfunction

	function automatic void assign_vendor(req_t r);
		logic [COST_W-1:0] cost;
		logic [TOTAL_W:0] sum;
		result_t res;
		if (r.command == CMD_LOAD) begin
			cap_left[r.depot] = r.amount;
			return;
		end
		if (r.distance > far_dist)
			far_dist = r.distance;
		if (cap_left[r.depot] >= r.amount && (!have_fit || r.distance < near_dist)) begin
			have_fit = 1'b1;
			near_dist = r.distance;
			near_depot = r.depot;
			near_amt = r.amount;
		end
		if (!r.last_depot)
			return;
		res = '0;
		res.assigned = have_fit;
		if (have_fit) begin
			res.chosen_depot = near_depot;
			cost = COST_W'(near_dist);
			// a load in mid vendor may have lowered the capacity below the demand
			if (cap_left[near_depot] >= near_amt)
				cap_left[near_depot] = cap_left[near_depot] - near_amt;
			else
				cap_left[near_depot] = '0;
		end else begin
			res.chosen_depot = '0;
			cost = COST_W'(far_dist) * PENALTY_FACTOR;
		end
		sum = {1'b0, run_sum} + (TOTAL_W + 1)'(cost);
		run_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
		res.vendor_index = VIDX_W'(vend_cnt);
		res.cost_added = cost;
		res.total_cost = run_sum;
		res.run_done = r.last_vendor;
		due_decisions.insert(due_decisions.size(), res);
		vend_cnt = vend_cnt + 1'b1;
		near_dist = '1;
		near_depot = '0;
		have_fit = 1'b0;
		near_amt = '0;
		far_dist = '0;
		if (r.last_vendor) begin
			run_sum = '0;
			vend_cnt = '0;
		end
	endfunction

	function automatic req_t mk_req(cmd_t c, int d, logic [DIST_W-1:0] dist_v,
			logic [AMOUNT_W-1:0] amt, logic ld, logic lv);
		req_t r;
		r.command = c;
		r.depot = DEPOT_W'(d);
		r.distance = dist_v;
		r.amount = amt;
		r.last_depot = ld;
		r.last_vendor = lv;
		return r;
	endfunction

	function automatic logic [DIST_W-1:0] rand_dist();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3, 4: return DIST_W'($urandom_range(15));
			default: return DIST_W'($urandom);
		endcase
	endfunction

	function automatic logic [AMOUNT_W-1:0] rand_demand();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3, 4, 5: return AMOUNT_W'($urandom_range(4095));
			6, 7: return AMOUNT_W'($urandom_range(65535));
			default: return AMOUNT_W'($urandom);
		endcase
	endfunction

	function automatic logic [AMOUNT_W-1:0] rand_cap();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3, 4: return AMOUNT_W'($urandom_range(65535));
			5, 6: return AMOUNT_W'($urandom_range(4095));
			default: return AMOUNT_W'($urandom);
		endcase
	endfunction

	// runs of vendors with random candidates, loads sprinkled in as noise and all depots reloaded after a closed run
	task automatic gen_vendors(input int n);
		int made;
		int k;
		int i;
		logic close;
		logic lv;
		logic reload;
		made = 0;
		reload = 1'b0;
		while (made < n) begin
			if (reload) begin
				for (i = 0; i < NUM_DEPOTS; i++)
					queue_req(mk_req(CMD_LOAD, i, rand_dist(), rand_cap(),
						1'($urandom_range(1)), 1'($urandom_range(1))));
				made += NUM_DEPOTS;
				reload = 1'b0;
			end
			k = $urandom_range(1, 8);
			lv = 1'b0;
			for (i = 0; i < k; i++) begin
				if ($urandom_range(99) < 6) begin
					queue_req(mk_req(CMD_LOAD, $urandom_range(7), rand_dist(),
						rand_cap(), 1'($urandom_range(1)), 1'($urandom_range(1))));
					made++;
				end
				close = (i == k - 1);
				lv = close ? ($urandom_range(11) == 0) : ($urandom_range(19) == 0);
				queue_req(mk_req(CMD_OFFER, $urandom_range(7), rand_dist(),
					rand_demand(), close, lv));
				made++;
			end
			if (lv)
				reload = 1'b1;
		end
	endtask

	task automatic gen_directed();
		// every depot loaded first, one load carries both flags
		queue_req(mk_req(CMD_LOAD, 0, '0, 24'hFFFFFF, 1'b0, 1'b0));
		queue_req(mk_req(CMD_LOAD, 1, '0, 24'd100, 1'b0, 1'b0));
		queue_req(mk_req(CMD_LOAD, 2, '0, 24'd0, 1'b0, 1'b0));
		queue_req(mk_req(CMD_LOAD, 3, '1, 24'd50, 1'b0, 1'b0));
		queue_req(mk_req(CMD_LOAD, 4, '0, 24'd1000, 1'b0, 1'b0));
		queue_req(mk_req(CMD_LOAD, 5, '0, 24'h800000, 1'b0, 1'b0));
		queue_req(mk_req(CMD_LOAD, 6, '0, 24'd7, 1'b1, 1'b1));
		queue_req(mk_req(CMD_LOAD, 7, '0, 24'hFFFFFF, 1'b0, 1'b0));
		// no fit, fit, equal distance fit keeps the first, far candidate closes
		queue_req(mk_req(CMD_OFFER, 2, 20'd5, 24'd1, 1'b0, 1'b0));
		queue_req(mk_req(CMD_OFFER, 1, 20'd10, 24'd100, 1'b0, 1'b0));
		queue_req(mk_req(CMD_OFFER, 3, 20'd10, 24'd50, 1'b0, 1'b0));
		queue_req(mk_req(CMD_OFFER, 0, 20'hFFFFF, 24'hFFFFFF, 1'b1, 1'b0));
		// penalty at the largest distance
		queue_req(mk_req(CMD_OFFER, 2, 20'hFFFFF, 24'd1, 1'b1, 1'b0));
		// last vendor flag without last depot is ignored
		queue_req(mk_req(CMD_OFFER, 4, 20'd0, 24'd0, 1'b0, 1'b1));
		queue_req(mk_req(CMD_OFFER, 4, 20'd0, 24'd500, 1'b0, 1'b0));
		// a load changes the capacity of the kept depot before the vendor closes
		queue_req(mk_req(CMD_LOAD, 4, '0, 24'd10, 1'b0, 1'b0));
		queue_req(mk_req(CMD_OFFER, 7, 20'd3, 24'd1, 1'b1, 1'b1));
		queue_req(mk_req(CMD_OFFER, 4, 20'd1, 24'd1, 1'b1, 1'b0));
		queue_req(mk_req(CMD_OFFER, 2, 20'd0, 24'd0, 1'b1, 1'b1));
	endtask

	// long run of penalties: vendor count wraps
	task automatic gen_wrap_run();
		int i;
		queue_req(mk_req(CMD_LOAD, 0, '0, '0, 1'b0, 1'b0));
		for (i = 0; i < WRAP_VENDORS; i++)
			queue_req(mk_req(CMD_OFFER, 0, 20'hFFFFF,
				AMOUNT_W'($urandom_range(1, 24'hFFFFFF)), 1'b1, i == WRAP_VENDORS - 1));
	endtask

	task automatic drain();
		while (pend_reqs.size() != 0 || in_valid || due_decisions.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			drv <= '0;
		end else begin
			if (in_valid && in_ready)
				assign_vendor(drv);
			if (!in_valid || in_ready) begin
				if (pend_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
					drv <= pend_reqs.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver hold-off counter
	always @(posedge clk) begin
		if (hold_start)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// decision monitor
	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_decisions.size() == 0) begin
					$display("%0t unexpected decision: vendor_index %0d total_cost %0d",
						$time, vendor_index, total_cost);
					errors++;
				end else begin
					exp_r = due_decisions.pop_front();
					check_field("vendor_index", exp_r.vendor_index, vendor_index);
					check_field("chosen_depot", exp_r.chosen_depot, chosen_depot);
					check_field("assigned", exp_r.assigned, assigned);
					check_field("cost_added", exp_r.cost_added, cost_added);
					check_field("total_cost", exp_r.total_cost, total_cost);
					check_field("run_done", exp_r.run_done, run_done);
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		gen_directed();
		gen_vendors(25);
		drain();
		@(negedge clk);
		send_idle = 71;
		recv_idle = 25;
		gen_vendors(25);
		drain();
		@(negedge clk);
		send_idle = 0;
		recv_idle = 0;
		gen_wrap_run();
		hold_start = 1'b1;
		@(negedge clk);
		hold_start = 1'b0;
		drain();
		@(negedge clk);
		gen_vendors(25);
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[greedy_capacitated_assign.f]
src/gca_pkg.sv
src/gca_cap_store.sv
src/gca_vendor_track.sv
src/greedy_capacitated_assign.sv
test/tb_greedy_capacitated_assign.sv
